@@ sv/char_class_lexer_dfa_assert.svh @@
// Assertion macros shared by the lexer checker.
`ifndef CHAR_CLASS_LEXER_DFA_ASSERT_SVH
`define CHAR_CLASS_LEXER_DFA_ASSERT_SVH

// Concurrent assertion on clk, switched off while rst is high.
`define CCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion on clk that also holds during reset.
`define CCL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/ccl_pkg.sv @@
// Package: widths, state and action codes, character classes and the next-state table.
package ccl_pkg;

  localparam int LINE_WIDTH = 24;
  localparam int COL_WIDTH  = 16;

  // Lexer state codes; the current code is also reported as token_class.
  localparam logic [3:0] ST_DELIM    = 4'd0;
  localparam logic [3:0] ST_SQUOTE   = 4'd1;
  localparam logic [3:0] ST_DQUOTE   = 4'd2;
  localparam logic [3:0] ST_SLASH    = 4'd3;
  localparam logic [3:0] ST_COMMENT  = 4'd4;
  localparam logic [3:0] ST_SINGLE   = 4'd5;
  localparam logic [3:0] ST_OPER     = 4'd6;
  localparam logic [3:0] ST_NUMBER   = 4'd7;
  localparam logic [3:0] ST_IDENT    = 4'd8;
  localparam logic [3:0] ST_SPACE    = 4'd9;
  localparam logic [3:0] ST_PREPROC  = 4'd10;
  localparam logic [3:0] ST_QCLOSED  = 4'd11;

  // Result action codes.
  localparam logic [2:0] ACT_APPEND  = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_SKIP    = 3'd2;
  localparam logic [2:0] ACT_ILLEGAL = 3'd3;
  localparam logic [2:0] ACT_ESCAPE  = 3'd4;
  localparam logic [2:0] ACT_END     = 3'd5;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_DOT       = 8'h2E;

  typedef struct packed {
    logic [3:0]            lex_state;
    logic                  escape_pending;
    logic [LINE_WIDTH-1:0] line_count;
    logic [COL_WIDTH-1:0]  column_count;
  } ccl_state_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic [2:0]            action;
    logic [3:0]            token_class;
    logic [LINE_WIDTH-1:0] line_number;
    logic [COL_WIDTH-1:0]  column_number;
  } ccl_result_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_NEWLINE;
  endfunction

  function automatic logic is_single(input logic [7:0] b);
    logic r;
    case (b)
      8'h3B, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C, 8'h3F, 8'h7E: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_oper(input logic [7:0] b);
    logic r;
    case (b)
      8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
      8'h2D, 8'h2B, 8'h3D, 8'h3A, 8'h3C, 8'h3E, 8'h7C: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Next machine state for byte b in state s; ST_QCLOSED and undefined codes lead to delimiter.
  function automatic logic [3:0] next_state(input logic [3:0] s, input logic [7:0] b);
    logic [3:0] n;
    n = ST_DELIM;
    case (s)
      ST_SQUOTE, ST_DQUOTE, ST_COMMENT, ST_PREPROC: begin
        if (b == CH_NEWLINE) n = ST_DELIM;
        else if (s == ST_SQUOTE && b == CH_SQUOTE) n = ST_QCLOSED;
        else if (s == ST_DQUOTE && b == CH_DQUOTE) n = ST_QCLOSED;
        else n = s;
      end
      ST_DELIM, ST_SLASH, ST_SINGLE, ST_OPER, ST_NUMBER, ST_IDENT, ST_SPACE: begin
        if (b == CH_HASH) n = ST_PREPROC;
        else if (b == CH_SQUOTE) n = ST_SQUOTE;
        else if (b == CH_DQUOTE) n = ST_DQUOTE;
        else begin
          case (s)
            ST_DELIM: begin
              if (is_alpha(b)) n = ST_IDENT;
              else if (is_digit(b)) n = ST_NUMBER;
              else if (is_space(b)) n = ST_SPACE;
              else if (is_single(b) || b == CH_DOT) n = ST_SINGLE;
              else if (is_oper(b)) n = ST_OPER;
              else if (b == CH_SLASH) n = ST_SLASH;
              else n = ST_DELIM;
            end
            ST_IDENT:  n = (is_alpha(b) || is_digit(b)) ? ST_IDENT : ST_DELIM;
            ST_NUMBER: n = (is_alpha(b) || is_digit(b) || b == CH_DOT) ? ST_NUMBER : ST_DELIM;
            ST_SPACE:  n = is_space(b) ? ST_SPACE : ST_DELIM;
            ST_OPER:   n = is_oper(b) ? ST_OPER : ST_DELIM;
            ST_SLASH: begin
              if (b == CH_SLASH) n = ST_COMMENT;
              else n = is_oper(b) ? ST_OPER : ST_DELIM;
            end
            default: n = ST_DELIM;
          endcase
        end
      end
      default: n = ST_DELIM;
    endcase
    return n;
  endfunction

endpackage

@@ sv/ccl_if.sv @@
// Channel interfaces of the lexer: text input, result output and configuration write.
interface ccl_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_marker;

  modport source (output valid, output text_byte, output end_marker, input ready);
  modport sink (input valid, input text_byte, input end_marker, output ready);
endinterface

interface ccl_result_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     out_byte;
  logic [2:0]                     action;
  logic [3:0]                     token_class;
  logic [ccl_pkg::LINE_WIDTH-1:0] line_number;
  logic [ccl_pkg::COL_WIDTH-1:0]  column_number;

  modport source (output valid, output out_byte, output action, output token_class,
                  output line_number, output column_number, input ready);
  modport sink (input valid, input out_byte, input action, input token_class,
                input line_number, input column_number, output ready);
endinterface

interface ccl_cfg_if;
  logic valid;
  logic ready;
  logic skip_whitespace;

  modport source (output valid, output skip_whitespace, input ready);
  modport sink (input valid, input skip_whitespace, output ready);
endinterface

@@ sv/ccl_step.sv @@
// One lexer step: result and next state for one transaction, purely combinational.
module ccl_step (
  input  ccl_pkg::ccl_state_t  cur,
  input  logic                 skip_whitespace,
  input  logic [7:0]           text_byte,
  input  logic                 end_marker,
  output ccl_pkg::ccl_result_t res,
  output ccl_pkg::ccl_state_t  nxt
);

  logic [3:0] n_run;
  logic [3:0] n_start;
  logic       at_start;

  assign n_run    = ccl_pkg::next_state(cur.lex_state, text_byte);
  assign n_start  = ccl_pkg::next_state(ccl_pkg::ST_DELIM, text_byte);
  // A running token that falls back to delimiter is closed; the byte starts a new one.
  assign at_start = (cur.lex_state == ccl_pkg::ST_DELIM) || (n_run == ccl_pkg::ST_DELIM);

  always_comb begin
    res.out_byte      = text_byte;
    res.action        = ccl_pkg::ACT_APPEND;
    res.token_class   = n_run;
    res.line_number   = cur.line_count;
    res.column_number = cur.column_count;
    nxt               = cur;

    if (end_marker) begin
      res.out_byte          = '0;
      res.action            = ccl_pkg::ACT_END;
      res.token_class       = ccl_pkg::ST_DELIM;
      nxt.lex_state         = ccl_pkg::ST_DELIM;
      nxt.escape_pending    = 1'b0;
      nxt.line_count        = ccl_pkg::LINE_WIDTH'(1);
      nxt.column_count      = '0;
    end else if (cur.escape_pending) begin
      res.action         = ccl_pkg::ACT_ESCAPE;
      res.token_class    = cur.lex_state;
      nxt.escape_pending = 1'b0;
    end else begin
      if (at_start) begin
        if (skip_whitespace && ccl_pkg::is_space(text_byte)) begin
          res.action      = ccl_pkg::ACT_SKIP;
          res.token_class = ccl_pkg::ST_DELIM;
        end else begin
          res.action      = (n_start == ccl_pkg::ST_DELIM) ? ccl_pkg::ACT_ILLEGAL
                                                           : ccl_pkg::ACT_START;
          res.token_class = n_start;
        end
      end
      nxt.lex_state = res.token_class;

      if (text_byte == ccl_pkg::CH_NEWLINE) begin
        if (cur.line_count != '1) nxt.line_count = cur.line_count + 1'b1;
        nxt.column_count = '0;
      end else if (cur.column_count != '1) begin
        nxt.column_count = cur.column_count + 1'b1;
      end

      nxt.escape_pending = (res.action == ccl_pkg::ACT_APPEND ||
                            res.action == ccl_pkg::ACT_START) &&
                           (text_byte == ccl_pkg::CH_BACKSLASH);
    end
  end

endmodule

@@ sv/char_class_lexer_dfa.sv @@
// Top level of the character-class lexer: registers, handshakes and the step logic.
// A result appears in the output register in the cycle after its input transaction.
// Throughput: one transaction per cycle unless the consumer stalls the output register.
// The input is ready whenever the output register is empty or is being emptied.
// Reset (rst, synchronous): state delimiter, no escape, line 1, column 0,
// skip_whitespace 0, output register empty; no transaction is taken during reset.
module char_class_lexer_dfa (
  input  logic                clk,
  input  logic                rst,
  ccl_text_if.sink            text,
  ccl_result_if.source        result,
  ccl_cfg_if.sink             cfg
);

  // Lexer state carried from one transaction to the next.
  ccl_pkg::ccl_state_t  state;
  ccl_pkg::ccl_state_t  state_next;
  ccl_pkg::ccl_result_t step_res;

  // Output register and its occupancy flag.
  ccl_pkg::ccl_result_t res_reg;
  logic                 res_valid;

  // Configuration register.
  logic skip_whitespace;

  logic text_take;

  // The configuration port is ready whenever reset is low; writes must arrive
  // only while the lexer is idle, which the block itself does not enforce.
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_whitespace <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      skip_whitespace <= cfg.skip_whitespace;
    end
  end

  // The output register frees up in the same cycle it is taken, so a new
  // transaction can enter every cycle while the consumer keeps up.
  assign text.ready = !rst && (!res_valid || result.ready);
  assign text_take  = text.valid && text.ready;

  // All work for a byte is done between the state registers and the output register.
  ccl_step u_step (
    .cur             (state),
    .skip_whitespace (skip_whitespace),
    .text_byte       (text.text_byte),
    .end_marker      (text.end_marker),
    .res             (step_res),
    .nxt             (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.lex_state      <= ccl_pkg::ST_DELIM;
      state.escape_pending <= 1'b0;
      state.line_count     <= ccl_pkg::LINE_WIDTH'(1);
      state.column_count   <= '0;
    end else if (text_take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (text_take) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Payload needs no reset; it is only looked at while res_valid is set.
  always_ff @(posedge clk) begin
    if (text_take) begin
      res_reg <= step_res;
    end
  end

  assign result.valid         = res_valid;
  assign result.out_byte      = res_reg.out_byte;
  assign result.action        = res_reg.action;
  assign result.token_class   = res_reg.token_class;
  assign result.line_number   = res_reg.line_number;
  assign result.column_number = res_reg.column_number;

endmodule

@@ sv/ccl_checker.sv @@
// Port-level checker for the lexer, attached to the top level by bind.
`include "char_class_lexer_dfa_assert.svh"

module ccl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           text_valid,
  input logic                           text_ready,
  input logic                           end_marker,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [7:0]                     out_byte,
  input logic [2:0]                     action,
  input logic [3:0]                     token_class,
  input logic [ccl_pkg::LINE_WIDTH-1:0] line_number,
  input logic [ccl_pkg::COL_WIDTH-1:0]  column_number
);

  // Reset leaves the output empty.
  `CCL_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")

  // A stalled result holds still.
  `CCL_ASSERT(a_stall_hold,
    result_valid && !result_ready |=> result_valid && $stable(out_byte) &&
    $stable(action) && $stable(token_class) && $stable(line_number) &&
    $stable(column_number), "stalled result changed")

  // An end marker produces an end result with a zero byte and delimiter class.
  `CCL_ASSERT(a_end_result,
    text_valid && text_ready && end_marker |=> result_valid &&
    action == ccl_pkg::ACT_END && out_byte == 8'd0 && token_class == ccl_pkg::ST_DELIM,
    "end marker did not give an end result")

  // Skipped, illegal and end results never report a token class.
  `CCL_ASSERT(a_no_class,
    result_valid && (action == ccl_pkg::ACT_SKIP || action == ccl_pkg::ACT_ILLEGAL ||
    action == ccl_pkg::ACT_END) |-> token_class == ccl_pkg::ST_DELIM,
    "token class set on a non-token result")

  // Lines count from one.
  `CCL_ASSERT(a_line_nonzero, result_valid |-> line_number != '0, "line number zero")

endmodule

bind char_class_lexer_dfa ccl_checker u_ccl_checker (
  .clk           (clk),
  .rst           (rst),
  .text_valid    (text.valid),
  .text_ready    (text.ready),
  .end_marker    (text.end_marker),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .out_byte      (result.out_byte),
  .action        (result.action),
  .token_class   (result.token_class),
  .line_number   (result.line_number),
  .column_number (result.column_number)
);

@@ bench/char_class_lexer_dfa_test.sv @@
// Self-checking testbench for the character-class lexer: stimulus, token prediction and checks.
`timescale 1ns / 100ps

module char_class_lexer_dfa_test;

  // The run ends here even if the lexer hangs. The slowest correct run has
  // every byte waiting out the longest gaps on both sides plus the long
  // receiver hold-off.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Tracks the lexer's token state, predicts one boundary mark for every
  // text transaction and compares each result transaction with the oldest
  // mark still waiting.
  class token_boundary_scoreboard;
    typedef enum {
      K_ALPHA, K_DIGIT, K_SPACE, K_SINGLE, K_OPER, K_DOT,
      K_SLASH, K_HASH, K_SQUOTE, K_DQUOTE, K_OTHER
    } byte_kind_e;

    logic                           skip_ws;
    logic [3:0]                     tok_state;
    logic                           escaped;
    logic [ccl_pkg::LINE_WIDTH-1:0] line_pos;
    logic [ccl_pkg::COL_WIDTH-1:0]  col_pos;
    ccl_pkg::ccl_result_t           expected_marks[$];
    int                             failures;
    int                             checked;
    int                             text_bytes;
    int                             end_markers;
    int                             action_seen[8];

    function new();
      skip_ws   = 1'b0;
      tok_state = ccl_pkg::ST_DELIM;
      escaped   = 1'b0;
      line_pos  = 1;
      col_pos   = 0;
      failures  = 0;
      checked   = 0;
      text_bytes  = 0;
      end_markers = 0;
      foreach (action_seen[i]) action_seen[i] = 0;
    endfunction

    function byte_kind_e kind_of(logic [7:0] b);
      if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_") return K_ALPHA;
      if (b >= "0" && b <= "9") return K_DIGIT;
      if (b == ccl_pkg::CH_SPACE || b == ccl_pkg::CH_TAB || b == ccl_pkg::CH_NEWLINE)
        return K_SPACE;
      if (b == ccl_pkg::CH_HASH) return K_HASH;
      if (b == ccl_pkg::CH_SQUOTE) return K_SQUOTE;
      if (b == ccl_pkg::CH_DQUOTE) return K_DQUOTE;
      if (b == ccl_pkg::CH_DOT) return K_DOT;
      if (b == ccl_pkg::CH_SLASH) return K_SLASH;
      case (b)
        ";", "(", ")", "{", "}", "[", "]", ",", "?", "~": return K_SINGLE;
        "!", "@", "$", "%", "^", "&", "*", "-", "+", "=", ":", "<", ">", "|": return K_OPER;
        default: return K_OTHER;
      endcase
    endfunction

    // Where the machine goes from state s on byte b. Quoted text, comments
    // and preprocessor lines run to a newline, quotes also to their closing
    // quote; other states follow the byte class, with '#' and quotes overriding.
    function logic [3:0] advance(logic [3:0] s, logic [7:0] b);
      byte_kind_e k;
      k = kind_of(b);
      case (s)
        ccl_pkg::ST_SQUOTE, ccl_pkg::ST_DQUOTE, ccl_pkg::ST_COMMENT,
        ccl_pkg::ST_PREPROC: begin
          if (b == ccl_pkg::CH_NEWLINE) return ccl_pkg::ST_DELIM;
          if (s == ccl_pkg::ST_SQUOTE && k == K_SQUOTE) return ccl_pkg::ST_QCLOSED;
          if (s == ccl_pkg::ST_DQUOTE && k == K_DQUOTE) return ccl_pkg::ST_QCLOSED;
          return s;
        end
        ccl_pkg::ST_DELIM, ccl_pkg::ST_SLASH, ccl_pkg::ST_SINGLE, ccl_pkg::ST_OPER,
        ccl_pkg::ST_NUMBER, ccl_pkg::ST_IDENT, ccl_pkg::ST_SPACE: begin
          if (k == K_HASH) return ccl_pkg::ST_PREPROC;
          if (k == K_SQUOTE) return ccl_pkg::ST_SQUOTE;
          if (k == K_DQUOTE) return ccl_pkg::ST_DQUOTE;
          case (s)
            ccl_pkg::ST_DELIM: begin
              case (k)
                K_ALPHA:         return ccl_pkg::ST_IDENT;
                K_DIGIT:         return ccl_pkg::ST_NUMBER;
                K_SPACE:         return ccl_pkg::ST_SPACE;
                K_SINGLE, K_DOT: return ccl_pkg::ST_SINGLE;
                K_OPER:          return ccl_pkg::ST_OPER;
                K_SLASH:         return ccl_pkg::ST_SLASH;
                default:         return ccl_pkg::ST_DELIM;
              endcase
            end
            ccl_pkg::ST_IDENT:
              return (k == K_ALPHA || k == K_DIGIT) ? ccl_pkg::ST_IDENT : ccl_pkg::ST_DELIM;
            ccl_pkg::ST_NUMBER:
              return (k == K_ALPHA || k == K_DIGIT || k == K_DOT) ? ccl_pkg::ST_NUMBER
                                                                  : ccl_pkg::ST_DELIM;
            ccl_pkg::ST_SPACE:
              return (k == K_SPACE) ? ccl_pkg::ST_SPACE : ccl_pkg::ST_DELIM;
            ccl_pkg::ST_OPER:
              return (k == K_OPER) ? ccl_pkg::ST_OPER : ccl_pkg::ST_DELIM;
            ccl_pkg::ST_SLASH: begin
              if (k == K_SLASH) return ccl_pkg::ST_COMMENT;
              return (k == K_OPER) ? ccl_pkg::ST_OPER : ccl_pkg::ST_DELIM;
            end
            default:   return ccl_pkg::ST_DELIM;
          endcase
        end
        default: return ccl_pkg::ST_DELIM;
      endcase
    endfunction

    // Called for every accepted text transaction; queues the mark it causes.
    function void note_byte(logic [7:0] b, logic endm);
      ccl_pkg::ccl_result_t mark;
      logic [3:0]           cur;
      logic [3:0]           nxt;
      mark.line_number   = line_pos;
      mark.column_number = col_pos;
      mark.out_byte      = b;
      if (endm) begin
        // An end marker reports where the text stopped and rewinds everything
        // but the whitespace setting.
        end_markers++;
        mark.out_byte    = 8'h00;
        mark.action      = ccl_pkg::ACT_END;
        mark.token_class = ccl_pkg::ST_DELIM;
        tok_state = ccl_pkg::ST_DELIM;
        escaped   = 1'b0;
        line_pos  = 1;
        col_pos   = 0;
      end else if (escaped) begin
        // The byte after a backslash goes in raw and does not move the position counters.
        text_bytes++;
        escaped          = 1'b0;
        mark.action      = ccl_pkg::ACT_ESCAPE;
        mark.token_class = tok_state;
      end else begin
        text_bytes++;
        cur = tok_state;
        nxt = advance(cur, b);
        // A byte that ends a running token opens the next one.
        if (cur != ccl_pkg::ST_DELIM && nxt == ccl_pkg::ST_DELIM) cur = ccl_pkg::ST_DELIM;
        if (cur == ccl_pkg::ST_DELIM) begin
          if (skip_ws && kind_of(b) == K_SPACE) begin
            mark.action      = ccl_pkg::ACT_SKIP;
            mark.token_class = ccl_pkg::ST_DELIM;
          end else begin
            nxt              = advance(ccl_pkg::ST_DELIM, b);
            mark.action      = (nxt == ccl_pkg::ST_DELIM) ? ccl_pkg::ACT_ILLEGAL
                                                          : ccl_pkg::ACT_START;
            mark.token_class = nxt;
          end
        end else begin
          mark.action      = ccl_pkg::ACT_APPEND;
          mark.token_class = nxt;
        end
        tok_state = mark.token_class;
        // Both position counters stop at all ones.
        if (b == ccl_pkg::CH_NEWLINE) begin
          if (line_pos != '1) line_pos++;
          col_pos = 0;
        end else if (col_pos != '1) begin
          col_pos++;
        end
        if ((mark.action == ccl_pkg::ACT_APPEND || mark.action == ccl_pkg::ACT_START) &&
            b == ccl_pkg::CH_BACKSLASH)
          escaped = 1'b1;
      end
      expected_marks = {expected_marks, mark};
    endfunction

    // Called for every accepted result transaction.
    function void check_mark(ccl_pkg::ccl_result_t got);
      ccl_pkg::ccl_result_t want;
      if (expected_marks.size() == 0) begin
        $error("result with no text byte behind it: byte 0x%02h action %0d",
               got.out_byte, got.action);
        failures++;
        return;
      end
      want = expected_marks.pop_front();
      checked++;
      action_seen[want.action]++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
        failures++;
      end
      if (got.action !== want.action) begin
        $error("action: expected %0d, got %0d", want.action, got.action);
        failures++;
      end
      if (got.token_class !== want.token_class) begin
        $error("token_class: expected %0d, got %0d", want.token_class, got.token_class);
        failures++;
      end
      if (got.line_number !== want.line_number) begin
        $error("line_number: expected %0d, got %0d", want.line_number, got.line_number);
        failures++;
      end
      if (got.column_number !== want.column_number) begin
        $error("column_number: expected %0d, got %0d", want.column_number, got.column_number);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_marks.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  ccl_text_if   text_ch ();
  ccl_result_if result_ch ();
  ccl_cfg_if    cfg_ch ();

  char_class_lexer_dfa dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  token_boundary_scoreboard sb = new();

  // Idling controls for the sender and the receiver, plus item and cycle counters.
  bit send_idle;
  bit recv_idle;
  int stall_hold;
  int items_sent;
  int cycles;

  // Character pools for building plausible source text.
  string alpha_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string digit_chars  = "0123456789";
  string oper_chars   = "!@$%^&*-+=:<>|";
  string single_chars = ";(){}[],?~.";
  string space_chars  = " \t\n";

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle counter and watchdog.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Both monitors sample at the rising edge, so they see the values that the
  // lexer itself acted on at that edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (text_ch.valid && text_ch.ready)
        sb.note_byte(text_ch.text_byte, text_ch.end_marker);
      if (result_ch.valid && result_ch.ready)
        sb.check_mark('{out_byte:      result_ch.out_byte,
                        action:        result_ch.action,
                        token_class:   result_ch.token_class,
                        line_number:   result_ch.line_number,
                        column_number: result_ch.column_number});
    end
  end

  // Receiver. A requested hold-off is counted out here, independently of the
  // sender, so the lexer's output register fills and its input stalls.
  initial begin
    int span;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_hold > 0) begin
        span = stall_hold;
        stall_hold = 0;
        result_ch.ready <= 1'b0;
        repeat (span) @(posedge clk);
      end else if (recv_idle && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] pick_from(string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // Offers one text transaction and returns at the edge that accepts it.
  // valid stays high from one transaction to the next unless a gap is drawn.
  task automatic push_byte(input logic [7:0] b, input logic endm);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    text_ch.valid      <= 1'b1;
    text_ch.text_byte  <= b;
    text_ch.end_marker <= endm;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Printable filler for the inside of strings, comments and directives.
  task automatic push_filler(input int n);
    repeat (n) push_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
  endtask

  // Stops offering text and waits until every predicted mark has come back.
  task automatic drain();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes the whitespace setting; only called while the lexer is idle.
  task automatic write_skip(input logic v);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.skip_whitespace <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.skip_ws = v;
  endtask

  // One piece of source text. Most pieces are well formed tokens with random
  // content; some are raw noise over the whole byte range, and a few are end
  // markers carrying a random byte that must be ignored.
  task automatic emit_fragment();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      push_byte(pick_from(alpha_chars), 1'b0);
      repeat ($urandom_range(0, 6))
        push_byte($urandom_range(0, 3) == 0 ? pick_from(digit_chars)
                                            : pick_from(alpha_chars), 1'b0);
    end else if (pick < 24) begin
      push_byte(pick_from(digit_chars), 1'b0);
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 5))
          0:       push_byte(ccl_pkg::CH_DOT, 1'b0);
          1:       push_byte(pick_from(alpha_chars), 1'b0);
          default: push_byte(pick_from(digit_chars), 1'b0);
        endcase
      end
    end else if (pick < 32) begin
      repeat ($urandom_range(1, 3)) push_byte(pick_from(oper_chars), 1'b0);
    end else if (pick < 38) begin
      push_byte(pick_from(single_chars), 1'b0);
    end else if (pick < 48) begin
      // Double-quoted string, sometimes with an escape of any byte value and
      // sometimes left open until the end of the line.
      push_byte(ccl_pkg::CH_DQUOTE, 1'b0);
      push_filler($urandom_range(0, 5));
      if ($urandom_range(0, 2) == 0) begin
        push_byte(ccl_pkg::CH_BACKSLASH, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_filler($urandom_range(0, 3));
      end
      push_byte($urandom_range(0, 7) == 0 ? ccl_pkg::CH_NEWLINE : ccl_pkg::CH_DQUOTE, 1'b0);
    end else if (pick < 53) begin
      push_byte(ccl_pkg::CH_SQUOTE, 1'b0);
      if ($urandom_range(0, 2) == 0) push_byte(ccl_pkg::CH_BACKSLASH, 1'b0);
      push_byte($urandom_range(0, 1) ? ccl_pkg::CH_SQUOTE : pick_from(alpha_chars), 1'b0);
      push_byte(ccl_pkg::CH_SQUOTE, 1'b0);
    end else if (pick < 60) begin
      push_byte(ccl_pkg::CH_SLASH, 1'b0);
      push_byte(ccl_pkg::CH_SLASH, 1'b0);
      push_filler($urandom_range(0, 8));
      if ($urandom_range(0, 3) == 0) begin
        // A backslash at the end of a comment line swallows the newline.
        push_byte(ccl_pkg::CH_BACKSLASH, 1'b0);
        push_byte(ccl_pkg::CH_NEWLINE, 1'b0);
        push_filler($urandom_range(0, 4));
      end
      push_byte(ccl_pkg::CH_NEWLINE, 1'b0);
    end else if (pick < 65) begin
      push_byte(ccl_pkg::CH_HASH, 1'b0);
      push_filler($urandom_range(0, 8));
      push_byte(ccl_pkg::CH_NEWLINE, 1'b0);
    end else if (pick < 78) begin
      repeat ($urandom_range(1, 4)) push_byte(pick_from(space_chars), 1'b0);
    end else if (pick < 83) begin
      push_byte(ccl_pkg::CH_SLASH, 1'b0);
      if ($urandom_range(0, 1)) push_byte(pick_from(oper_chars), 1'b0);
    end else if (pick < 97) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      push_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic random_text(input int target, input int hold_at);
    int first;
    bit held;
    first = items_sent;
    held  = 1'b0;
    while (items_sent - first < target) begin
      if (!held && hold_at > 0 && items_sent - first >= hold_at) begin
        stall_hold = 240;
        held = 1'b1;
      end
      emit_fragment();
    end
  endtask

  initial begin
    logic [7:0] opening[$];
    text_ch.valid          <= 1'b0;
    text_ch.text_byte      <= 8'h00;
    text_ch.end_marker     <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.skip_whitespace <= 1'b0;
    rst        <= 1'b1;
    send_idle  = 1'b0;
    recv_idle  = 1'b0;
    stall_hold = 0;
    items_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed opening with whitespace tokenized: the lowest and highest byte
    // codes dropped at token start, a whitespace token, an identifier cut by
    // a dot, an operator cut by a slash, a comment whose escaped newline does
    // not count as a line, a preprocessor line, a string with an escaped
    // quote, a quote closed and directly followed by another quote, a byte
    // above 127 inside quotes, and an end marker with a junk byte.
    write_skip(1'b0);
    opening = {8'h00, 8'hFF, ccl_pkg::CH_SPACE, ccl_pkg::CH_TAB, 8'h61, 8'h39,
               ccl_pkg::CH_DOT, 8'h2B, 8'h3D, ccl_pkg::CH_SLASH, ccl_pkg::CH_SLASH,
               ccl_pkg::CH_BACKSLASH, ccl_pkg::CH_NEWLINE, ccl_pkg::CH_NEWLINE,
               ccl_pkg::CH_HASH, ccl_pkg::CH_NEWLINE, ccl_pkg::CH_DQUOTE,
               ccl_pkg::CH_BACKSLASH, ccl_pkg::CH_DQUOTE, ccl_pkg::CH_DQUOTE,
               ccl_pkg::CH_SQUOTE, 8'h80, ccl_pkg::CH_SQUOTE};
    foreach (opening[i]) push_byte(opening[i], 1'b0);
    push_byte(8'hA5, 1'b1);
    drain();

    // Whitespace skipped: at token start and right after an identifier.
    write_skip(1'b1);
    push_byte(ccl_pkg::CH_NEWLINE, 1'b0);
    push_byte(8'h78, 1'b0);
    push_byte(ccl_pkg::CH_SPACE, 1'b0);
    push_byte(8'h5A, 1'b1);
    drain();

    // Random text with idling on both sides and one long receiver hold-off.
    send_idle = 1'b1;
    recv_idle = 1'b1;
    write_skip(1'b0);
    random_text(450, 120);
    drain();

    write_skip(1'b1);
    random_text(450, 0);
    drain();

    write_skip(1'b1);
    random_text(450, 0);
    drain();

    // Last part of the run at full rate with no idling anywhere.
    send_idle = 1'b0;
    recv_idle = 1'b0;
    write_skip(1'b0);
    random_text(450, 0);
    drain();

    if (sb.outstanding() != 0) begin
      $error("%0d predicted results never arrived", sb.outstanding());
      sb.failures++;
    end

    $display("Summary: %0d results checked for %0d text bytes and %0d end markers,",
             sb.checked, sb.text_bytes, sb.end_markers);
    $display("  %0d token starts, %0d escapes, %0d skipped blanks, %0d dropped bytes.",
             sb.action_seen[ccl_pkg::ACT_START], sb.action_seen[ccl_pkg::ACT_ESCAPE],
             sb.action_seen[ccl_pkg::ACT_SKIP], sb.action_seen[ccl_pkg::ACT_ILLEGAL]);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
